// ===== hdl/led_bar_mode_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// LED bar mode controller assertion macros
// Shorthand for the concurrent checks of the core, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_BAR_MODE_CONTROLLER_CORE_DEFINES_SVH
`define LED_BAR_MODE_CONTROLLER_CORE_DEFINES_SVH

// Condition must imply the consequence in the same cycle.
`define LBMC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must imply the consequence in the next cycle.
`define LBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lbmc_pkg.sv =====
// ----------------------------------------------------------------------------
// LED bar mode controller package
// Widths, register indexes, state encodings and shared helpers.
// ----------------------------------------------------------------------------
package lbmc_pkg;

	localparam int LED_COUNT   = 4;
	localparam int LED_IDX_W   = $clog2(LED_COUNT);
	localparam int LIT_W       = $clog2(LED_COUNT + 1);
	localparam int TIME_BITS   = 32;
	localparam int INTERVAL_W  = 16;
	localparam int TEMP_W      = 15;
	localparam int OFFSET_W    = 11;
	localparam int MODE_W      = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [TIME_BITS-1:0]       time_t;
	typedef logic [INTERVAL_W-1:0]      interval_t;
	typedef logic signed [TEMP_W-1:0]   temp_t;
	typedef logic signed [OFFSET_W-1:0] offset_t;
	typedef logic [LED_COUNT-1:0]       lamp_t;
	typedef logic [LIT_W-1:0]           lit_t;
	typedef logic [MODE_W-1:0]          mode_t;

	// Register indexes on the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RAMP_ON    = 3'd0,
		REG_RAMP_OFF   = 3'd1,
		REG_SAMPLE     = 3'd2,
		REG_INIT_BASE  = 3'd3,
		REG_OFFSET0    = 3'd4,
		REG_OFFSET1    = 3'd5,
		REG_OFFSET2    = 3'd6,
		REG_OFFSET3    = 3'd7
	} cfg_reg_t;

	// Codes on active_mode
	localparam mode_t MODE_IDLE = 2'd0;
	localparam mode_t MODE_RAMP = 2'd1;
	localparam mode_t MODE_TEMP = 2'd2;

	typedef enum logic [2:0] {
		TOP_IDLE = 3'b001,
		TOP_RAMP = 3'b010,
		TOP_TEMP = 3'b100
	} top_mode_t;

	typedef enum logic [4:0] {
		RP_INIT = 5'b00001,
		RP_ON   = 5'b00010,
		RP_OFF  = 5'b00100,
		RP_MIN  = 5'b01000,
		RP_MAX  = 5'b10000
	} ramp_phase_t;

	typedef enum logic [3:0] {
		TP_INIT   = 4'b0001,
		TP_IDLE   = 4'b0010,
		TP_SAMPLE = 4'b0100,
		TP_BASE   = 4'b1000
	} temp_phase_t;

	typedef struct packed {
		interval_t                   ramp_on;
		interval_t                   ramp_off;
		interval_t                   sample;
		temp_t                       initial_base;
		logic [LED_COUNT-1:0][OFFSET_W-1:0] offset;
	} cfg_t;

	typedef struct packed {
		ramp_phase_t phase;
		lit_t        lit;
		time_t       mark;
	} ramp_state_t;

	typedef struct packed {
		temp_phase_t phase;
		time_t       last;
		temp_t       base;
	} temp_state_t;

	typedef struct packed {
		logic  lamp_we;
		lamp_t lamp;
		logic  sampled;
	} temp_out_t;

	// Wrapping elapsed-time check
	function automatic logic time_reached(time_t now, time_t mark, interval_t ivl);
		time_t diff;
		diff = now - mark;
		return diff >= TIME_BITS'(ivl);
	endfunction

	function automatic mode_t mode_code(top_mode_t m);
		mode_t code;
		unique case (m)
			TOP_RAMP: code = MODE_RAMP;
			TOP_TEMP: code = MODE_TEMP;
			default:  code = MODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/lbmc_if.sv =====
// ----------------------------------------------------------------------------
// LED bar mode controller channels
// Valid/ready request channels for loop items and results.
// ----------------------------------------------------------------------------
interface lbmc_in_if import lbmc_pkg::*; ();
	logic  valid;
	logic  ready;
	time_t now_ms;
	logic  ramp_select;
	logic  button_held;
	temp_t temperature;

	modport source (output valid, now_ms, ramp_select, button_held, temperature,
		input ready);
	modport sink (input valid, now_ms, ramp_select, button_held, temperature,
		output ready);
endinterface

interface lbmc_out_if import lbmc_pkg::*; ();
	logic  valid;
	logic  ready;
	lamp_t led_mask;
	mode_t active_mode;
	logic  sample_taken;
	temp_t base_temperature;

	modport source (output valid, led_mask, active_mode, sample_taken, base_temperature,
		input ready);
	modport sink (input valid, led_mask, active_mode, sample_taken, base_temperature,
		output ready);
endinterface

// ===== hdl/lbmc_cfg.sv =====
// ----------------------------------------------------------------------------
// LED bar mode controller configuration registers
// Write-only register bank with reset defaults.
// ----------------------------------------------------------------------------
module lbmc_cfg import lbmc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   we,
	input  logic [CFG_INDEX_W-1:0] index,
	input  logic [CFG_DATA_W-1:0]  wdata,
	output cfg_t                   cfg
);

	localparam interval_t RAMP_ON_RST  = 16'd1000;
	localparam interval_t RAMP_OFF_RST = 16'd500;
	localparam interval_t SAMPLE_RST   = 16'd500;
	localparam temp_t     BASE_RST     = 15'sd2400;
	localparam offset_t   OFFSET0_RST  = -11'sd100;
	localparam offset_t   OFFSET1_RST  = 11'sd50;
	localparam offset_t   OFFSET2_RST  = 11'sd100;
	localparam offset_t   OFFSET3_RST  = 11'sd150;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_on      <= RAMP_ON_RST;
			cfg_q.ramp_off     <= RAMP_OFF_RST;
			cfg_q.sample       <= SAMPLE_RST;
			cfg_q.initial_base <= BASE_RST;
			cfg_q.offset[0]    <= OFFSET0_RST;
			cfg_q.offset[1]    <= OFFSET1_RST;
			cfg_q.offset[2]    <= OFFSET2_RST;
			cfg_q.offset[3]    <= OFFSET3_RST;
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				REG_RAMP_ON:   cfg_q.ramp_on      <= wdata[INTERVAL_W-1:0];
				REG_RAMP_OFF:  cfg_q.ramp_off     <= wdata[INTERVAL_W-1:0];
				REG_SAMPLE:    cfg_q.sample       <= wdata[INTERVAL_W-1:0];
				REG_INIT_BASE: cfg_q.initial_base <= wdata[TEMP_W-1:0];
				REG_OFFSET0:   cfg_q.offset[0]    <= wdata[OFFSET_W-1:0];
				REG_OFFSET1:   cfg_q.offset[1]    <= wdata[OFFSET_W-1:0];
				REG_OFFSET2:   cfg_q.offset[2]    <= wdata[OFFSET_W-1:0];
				REG_OFFSET3:   cfg_q.offset[3]    <= wdata[OFFSET_W-1:0];
				default:       cfg_q.ramp_on      <= cfg_q.ramp_on;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/lbmc_ramp.sv =====
// ----------------------------------------------------------------------------
// LED bar mode controller ramp step
// Next-state logic of the ramp machine for one loop pass.
// ----------------------------------------------------------------------------
module lbmc_ramp import lbmc_pkg::*; (
	input  ramp_state_t cur,
	input  lamp_t       lamp_in,
	input  time_t       now,
	input  logic        held,
	input  interval_t   on_ivl,
	input  interval_t   off_ivl,
	output ramp_state_t nxt,
	output lamp_t       lamp_out
);

	lit_t lit_dec;
	logic on_due;
	logic off_due;

	assign lit_dec = cur.lit - LIT_W'(1);
	assign on_due  = time_reached(now, cur.mark, on_ivl);
	assign off_due = time_reached(now, cur.mark, off_ivl);

	always_comb begin
		nxt      = cur;
		lamp_out = lamp_in;
		unique case (cur.phase)
			RP_ON: begin
				if (!held) begin
					nxt.phase = RP_OFF;
					nxt.mark  = now;
				end else if (on_due) begin
					if (cur.lit < LIT_W'(LED_COUNT)) begin
						lamp_out[cur.lit[LED_IDX_W-1:0]] = 1'b1;
						nxt.lit = cur.lit + LIT_W'(1);
					end else begin
						nxt.phase = RP_MAX;
						nxt.lit   = LIT_W'(LED_COUNT);
					end
					nxt.mark = now;
				end
			end
			RP_OFF: begin
				if (held) begin
					nxt.phase = RP_ON;
					nxt.mark  = now;
				end else if (off_due) begin
					if (cur.lit != '0) begin
						nxt.lit = lit_dec;
						// counts at or above the bar width darken nothing
						if (lit_dec < LIT_W'(LED_COUNT))
							lamp_out[lit_dec[LED_IDX_W-1:0]] = 1'b0;
					end else begin
						nxt.phase = RP_MIN;
						nxt.lit   = '0;
					end
					nxt.mark = now;
				end
			end
			RP_MIN: begin
				if (held) begin
					nxt.phase = RP_ON;
					nxt.mark  = now;
					nxt.lit   = '0;
				end
			end
			RP_MAX: begin
				if (!held) begin
					nxt.phase = RP_OFF;
					nxt.mark  = now;
				end
			end
			default: begin
				// first pass after entering ramp mode: clear the bar
				lamp_out  = '0;
				nxt.phase = RP_MIN;
				nxt.lit   = '0;
			end
		endcase
	end

endmodule

// ===== hdl/lbmc_temp.sv =====
// ----------------------------------------------------------------------------
// LED bar mode controller temperature step
// Next-state logic of the temperature machine: sampling, thresholds, base.
// ----------------------------------------------------------------------------
module lbmc_temp import lbmc_pkg::*; (
	input  temp_state_t cur,
	input  time_t       now,
	input  logic        held,
	input  temp_t       temperature,
	input  cfg_t        cfg,
	output temp_state_t nxt,
	output temp_out_t   res
);

	temp_phase_t                phase;
	logic signed [TEMP_W:0]     temp_ext;
	logic signed [TEMP_W:0]     thr [LED_COUNT];
	lamp_t                      cmp;

	assign temp_ext = (TEMP_W+1)'(temperature);

	always_comb begin
		for (int i = 0; i < LED_COUNT; i++) begin
			thr[i] = (TEMP_W+1)'(cur.base) + (TEMP_W+1)'($signed(cfg.offset[i]));
			cmp[i] = temp_ext >= thr[i];
		end
	end

	// a held button always pulls the machine into the base wait
	assign phase = held ? TP_BASE : cur.phase;

	always_comb begin
		nxt         = cur;
		res.lamp_we = 1'b0;
		res.lamp    = cmp;
		res.sampled = 1'b0;
		unique case (phase)
			TP_INIT: begin
				nxt.base  = cfg.initial_base;
				nxt.phase = TP_SAMPLE;
			end
			TP_IDLE: begin
				nxt.phase = TP_IDLE;
				if (time_reached(now, cur.last, cfg.sample))
					nxt.phase = TP_SAMPLE;
			end
			TP_SAMPLE: begin
				nxt.last    = now;
				nxt.phase   = TP_IDLE;
				res.lamp_we = 1'b1;
				res.sampled = 1'b1;
			end
			TP_BASE: begin
				nxt.phase = TP_BASE;
				if (!held) begin
					nxt.base    = temperature;
					nxt.phase   = TP_SAMPLE;
					res.sampled = 1'b1;
				end
			end
			default: nxt.phase = TP_INIT;
		endcase
	end

endmodule

// ===== hdl/led_bar_mode_controller_core.sv =====
// ----------------------------------------------------------------------------
// LED bar mode controller core
// Ramp and temperature display modes for a four-LED bar, one loop pass per item.
// ----------------------------------------------------------------------------
// Takes one loop pass per clock cycle while the result side does not stall. An
// accepted request lands in an input register; once its pass can move on, the
// mode state registers and the result register load from it on the same edge,
// and the result is offered from the result register. Back-to-back requests flow
// at one per cycle while results are taken. The input side stays ready while the
// input register is empty or its pass can move on, which it does when the result
// register is empty or is being taken; a stalled result stops the input register
// and the mode state registers. Configuration writes take effect on the next cycle
// and belong between passes, with no request in flight.
`include "led_bar_mode_controller_core_defines.svh"

module led_bar_mode_controller_core import lbmc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	lbmc_in_if.sink                item_in,
	lbmc_out_if.source             result_out,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t        cfg;

	logic        valid_s1;
	time_t       now_s1;
	logic        slider_s1;
	logic        held_s1;
	temp_t       temp_s1;
	logic        advance;

	top_mode_t   top_q, top_nxt;
	ramp_state_t ramp_q, ramp_calc, ramp_nxt;
	temp_state_t temp_q, temp_calc, temp_nxt;
	lamp_t       lamp_q, lamp_nxt, ramp_lamp;
	temp_out_t   temp_res;
	logic        sampled;

	logic        out_valid_q;
	lamp_t       led_mask_q;
	mode_t       mode_q;
	logic        sample_q;
	temp_t       base_q;

	lbmc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	lbmc_ramp u_ramp (
		.cur      (ramp_q),
		.lamp_in  (lamp_q),
		.now      (now_s1),
		.held     (held_s1),
		.on_ivl   (cfg.ramp_on),
		.off_ivl  (cfg.ramp_off),
		.nxt      (ramp_calc),
		.lamp_out (ramp_lamp)
	);

	lbmc_temp u_temp (
		.cur         (temp_q),
		.now         (now_s1),
		.held        (held_s1),
		.temperature (temp_s1),
		.cfg         (cfg),
		.nxt         (temp_calc),
		.res         (temp_res)
	);

	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			now_s1    <= item_in.now_ms;
			slider_s1 <= item_in.ramp_select;
			held_s1   <= item_in.button_held;
			temp_s1   <= item_in.temperature;
		end
	end

	// Mode selection; the pass that changes mode does not run either machine
	always_comb begin
		top_nxt  = top_q;
		ramp_nxt = ramp_q;
		temp_nxt = temp_q;
		lamp_nxt = lamp_q;
		sampled  = 1'b0;
		unique case (top_q)
			TOP_IDLE: begin
				if (slider_s1) begin
					top_nxt        = TOP_RAMP;
					ramp_nxt.phase = RP_INIT;
				end else begin
					top_nxt = TOP_TEMP;
				end
			end
			TOP_RAMP: begin
				if (!slider_s1) begin
					top_nxt        = TOP_TEMP;
					ramp_nxt.phase = RP_INIT;
				end else begin
					ramp_nxt = ramp_calc;
					lamp_nxt = ramp_lamp;
				end
			end
			TOP_TEMP: begin
				// slider is ignored during the base wait
				if (slider_s1 && temp_q.phase != TP_BASE) begin
					top_nxt = TOP_RAMP;
				end else begin
					temp_nxt = temp_calc;
					sampled  = temp_res.sampled;
					if (temp_res.lamp_we)
						lamp_nxt = temp_res.lamp;
				end
			end
			default: top_nxt = TOP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= TOP_IDLE;
			ramp_q <= '{phase: RP_INIT, lit: '0, mark: '0};
			temp_q <= '{phase: TP_INIT, last: '0, base: '0};
			lamp_q <= '0;
		end else if (advance) begin
			top_q  <= top_nxt;
			ramp_q <= ramp_nxt;
			temp_q <= temp_nxt;
			lamp_q <= lamp_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_mask_q <= lamp_nxt;
			mode_q     <= mode_code(top_nxt);
			sample_q   <= sampled;
			base_q     <= temp_nxt.base;
		end
	end

	assign result_out.valid            = out_valid_q;
	assign result_out.led_mask         = led_mask_q;
	assign result_out.active_mode      = mode_q;
	assign result_out.sample_taken     = sample_q;
	assign result_out.base_temperature = base_q;

	`LBMC_ASSERT_IMPLIES(a_max_full, ramp_q.phase == RP_MAX,
		(ramp_q.lit == LIT_W'(LED_COUNT)) && (lamp_q == '1), "ramp top reached without full bar")
	`LBMC_ASSERT_IMPLIES(a_min_empty, ramp_q.phase == RP_MIN, ramp_q.lit == '0,
		"ramp bottom with nonzero count")
	`LBMC_ASSERT_IMPLIES(a_sample_mode, result_out.valid && result_out.sample_taken,
		result_out.active_mode == MODE_TEMP, "sample reported outside temperature mode")
	`LBMC_ASSERT_NEXT(a_result_lands, advance, result_out.valid,
		"advanced pass left no result")

endmodule

// ===== sim/led_bar_mode_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// LED bar mode controller core testbench
// Drives loop passes through the request channel under random bursts and
// result stalls. Each accepted pass is run through a local model of the ramp
// and temperature machines, and every result is compared field by field with
// the oldest expected one. Register settings change between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_bar_mode_controller_core_tb;
	import lbmc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 80;
	localparam int HOLD_AFTER  = 200;

	typedef struct packed {
		time_t now_ms;
		logic  slider;
		logic  held;
		temp_t temp;
	} loop_req_t;

	typedef struct packed {
		lamp_t mask;
		mode_t mode;
		logic  sampled;
		temp_t base;
	} bar_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	lbmc_in_if  req_ch ();
	lbmc_out_if res_ch ();

	led_bar_mode_controller_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (req_ch),
		.result_out (res_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register copy
	interval_t on_ivl;
	interval_t off_ivl;
	interval_t sample_ivl;
	temp_t     init_base;
	offset_t   led_offset [LED_COUNT];

	// Controller state
	top_mode_t   top_now;
	ramp_phase_t ramp_now;
	int          lit_now;
	time_t       ramp_since;
	temp_phase_t temp_now;
	time_t       sample_since;
	temp_t       base_now;
	lamp_t       lamps;

	loop_req_t   pending_reqs [$];
	bar_result_t bar_expect_q [$];
	int          req_total;
	int          results_done;
	int          fail_count;
	int          cycle_count;

	// Stimulus generator state
	time_t gen_now;
	int    gen_step;
	int    gen_center;
	logic  gen_held;

	function automatic void step_ramp(input time_t now, input logic held);
		time_t gone;
		gone = now - ramp_since;
		case (ramp_now)
			RP_ON: begin
				if (!held) begin
					ramp_now   = RP_OFF;
					ramp_since = now;
				end else if (gone >= on_ivl) begin
					if (lit_now < LED_COUNT) begin
						lamps[lit_now] = 1'b1;
						lit_now++;
					end else begin
						ramp_now = RP_MAX;
					end
					ramp_since = now;
				end
			end
			RP_OFF: begin
				if (held) begin
					ramp_now   = RP_ON;
					ramp_since = now;
				end else if (gone >= off_ivl) begin
					if (lit_now > 0) begin
						lit_now--;
						lamps[lit_now] = 1'b0;
					end else begin
						ramp_now = RP_MIN;
					end
					ramp_since = now;
				end
			end
			RP_MIN: begin
				if (held) begin
					ramp_now   = RP_ON;
					ramp_since = now;
					lit_now    = 0;
				end
			end
			RP_MAX: begin
				if (!held) begin
					ramp_now   = RP_OFF;
					ramp_since = now;
				end
			end
			default: begin
				lamps    = '0;
				ramp_now = RP_MIN;
				lit_now  = 0;
			end
		endcase
	endfunction

	function automatic logic step_temp(input time_t now, input logic held, input temp_t t);
		time_t gone;
		logic  took;
		int    i;
		took = 1'b0;
		gone = now - sample_since;
		if (held)
			temp_now = TP_BASE;
		case (temp_now)
			TP_INIT: begin
				base_now = init_base;
				temp_now = TP_SAMPLE;
			end
			TP_IDLE: begin
				if (gone >= sample_ivl)
					temp_now = TP_SAMPLE;
			end
			TP_SAMPLE: begin
				sample_since = now;
				for (i = 0; i < LED_COUNT; i++)
					lamps[i] = (int'(t) >= int'(base_now) + int'(led_offset[i]));
				temp_now = TP_IDLE;
				took     = 1'b1;
			end
			default: begin
				// waiting for the button release, which captures the new base
				if (!held) begin
					base_now = t;
					temp_now = TP_SAMPLE;
					took     = 1'b1;
				end
			end
		endcase
		return took;
	endfunction

	function automatic bar_result_t run_loop_pass(input time_t now, input logic slider,
			input logic held, input temp_t t);
		bar_result_t r;
		logic        took;
		took = 1'b0;
		case (top_now)
			TOP_RAMP: begin
				if (!slider) begin
					top_now  = TOP_TEMP;
					ramp_now = RP_INIT;
				end else begin
					step_ramp(now, held);
				end
			end
			TOP_TEMP: begin
				if (slider && temp_now != TP_BASE)
					top_now = TOP_RAMP;
				else
					took = step_temp(now, held, t);
			end
			default: begin
				top_now  = slider ? TOP_RAMP : TOP_TEMP;
				ramp_now = RP_INIT;
			end
		endcase
		r.mask    = lamps;
		r.sampled = took;
		r.base    = base_now;
		case (top_now)
			TOP_RAMP: r.mode = MODE_RAMP;
			TOP_TEMP: r.mode = MODE_TEMP;
			default:  r.mode = MODE_IDLE;
		endcase
		return r;
	endfunction

	// Request driver: bursts of random length separated by random gaps
	loop_req_t next_req;
	int        burst_left;
	int        gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			burst_left   <= 0;
			gap_left     <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				bar_expect_q.push_back(run_loop_pass(req_ch.now_ms, req_ch.ramp_select,
					req_ch.button_held, req_ch.temperature));
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left != 0) begin
					gap_left     <= gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.now_ms      <= next_req.now_ms;
					req_ch.ramp_select <= next_req.slider;
					req_ch.button_held <= next_req.held;
					req_ch.temperature <= next_req.temp;
					if (burst_left != 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 20);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: rotating stall pattern, plus one long hold-off
	logic [15:0] stall_pattern;
	int          pattern_age;
	int          hold_left;
	logic        hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready  <= 1'b0;
			stall_pattern <= '1;
			pattern_age   <= 0;
			hold_left     <= 0;
			hold_done     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (!hold_done && results_done >= HOLD_AFTER) begin
			hold_left    <= LONG_HOLD;
			hold_done    <= 1'b1;
			res_ch.ready <= 1'b0;
		end else if (pattern_age == 0) begin
			stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF :
				16'($urandom() | $urandom());
			pattern_age   <= 47;
			res_ch.ready  <= stall_pattern[0];
		end else begin
			stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
			pattern_age   <= pattern_age - 1;
			res_ch.ready  <= stall_pattern[0];
		end
	end

	task automatic note_mismatch(input string what, input int want, input logic signed [31:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	// Result checker
	bar_result_t want;

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_done++;
			if (bar_expect_q.size() == 0) begin
				fail_count++;
				$display("%0t: result with no request pending, led_mask %0d", $time,
					res_ch.led_mask);
			end else begin
				want = bar_expect_q.pop_front();
				if (res_ch.led_mask !== want.mask)
					note_mismatch("led_mask", want.mask, res_ch.led_mask);
				if (res_ch.active_mode !== want.mode)
					note_mismatch("active_mode", want.mode, res_ch.active_mode);
				if (res_ch.sample_taken !== want.sampled)
					note_mismatch("sample_taken", want.sampled, res_ch.sample_taken);
				if (res_ch.base_temperature !== want.base)
					note_mismatch("base_temperature", want.base, res_ch.base_temperature);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("led_bar_mode_controller_core verification failed");
			$finish;
		end
	end

	task automatic queue_req(input time_t now, input logic slider, input logic held,
			input temp_t t);
		loop_req_t r;
		r.now_ms = now;
		r.slider = slider;
		r.held   = held;
		r.temp   = t;
		pending_reqs.push_back(r);
		req_total++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_RAMP_ON:   on_ivl        = data;
			REG_RAMP_OFF:  off_ivl       = data;
			REG_SAMPLE:    sample_ivl    = data;
			REG_INIT_BASE: init_base     = data[TEMP_W-1:0];
			REG_OFFSET0:   led_offset[0] = data[OFFSET_W-1:0];
			REG_OFFSET1:   led_offset[1] = data[OFFSET_W-1:0];
			REG_OFFSET2:   led_offset[2] = data[OFFSET_W-1:0];
			default:       led_offset[3] = data[OFFSET_W-1:0];
		endcase
	endtask

	task automatic load_setup(input int ramp_on, input int ramp_off, input int smp,
			input int ibase, input int o0, input int o1, input int o2, input int o3);
		write_reg(REG_RAMP_ON, 16'(ramp_on));
		write_reg(REG_RAMP_OFF, 16'(ramp_off));
		write_reg(REG_SAMPLE, 16'(smp));
		write_reg(REG_INIT_BASE, 16'(ibase));
		write_reg(REG_OFFSET0, 16'(o0));
		write_reg(REG_OFFSET1, 16'(o1));
		write_reg(REG_OFFSET2, 16'(o2));
		write_reg(REG_OFFSET3, 16'(o3));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Hold new requests until every result is back, then let the pipe settle
	task automatic drain();
		while (results_done < req_total)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic advance_clock();
		case ($urandom_range(0, 24))
			0:       gen_now = $urandom();
			1:       gen_now += $urandom_range(0, 140000);
			default: gen_now += $urandom_range(0, gen_step);
		endcase
	endtask

	function automatic temp_t pick_temp();
		int v;
		if ($urandom_range(0, 7) == 0)
			return temp_t'($urandom());
		v = gen_center + int'($urandom_range(0, 2600)) - 1300;
		if (v > 16383)
			v = 16383;
		if (v < -16384)
			v = -16384;
		return temp_t'(v);
	endfunction

	// Mostly ramp and temperature sessions with random content, some pure noise
	task automatic queue_random(input int count);
		int    left;
		int    run;
		int    kind;
		logic  was_held;
		temp_t t;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			run  = $urandom_range(3, 18);
			if (run > left)
				run = left;
			left -= run;
			repeat (run) begin
				if (kind == 0) begin
					queue_req($urandom(), 1'($urandom()), 1'($urandom()), temp_t'($urandom()));
				end else if (kind <= 4) begin
					if ($urandom_range(0, 3) == 0)
						gen_held = !gen_held;
					advance_clock();
					queue_req(gen_now, 1'b1, gen_held, pick_temp());
				end else begin
					was_held = gen_held;
					if (gen_held)
						gen_held = ($urandom_range(0, 1) == 0);
					else
						gen_held = ($urandom_range(0, 9) == 0);
					advance_clock();
					t = pick_temp();
					// track the base the release will capture
					if (was_held && !gen_held)
						gen_center = int'(t);
					queue_req(gen_now, ($urandom_range(0, 11) == 0), gen_held, t);
				end
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.now_ms      = '0;
		req_ch.ramp_select = 1'b0;
		req_ch.button_held = 1'b0;
		req_ch.temperature = '0;
		res_ch.ready       = 1'b0;
		on_ivl        = 16'd1000;
		off_ivl       = 16'd500;
		sample_ivl    = 16'd500;
		init_base     = 15'sd2400;
		led_offset[0] = -11'sd100;
		led_offset[1] = 11'sd50;
		led_offset[2] = 11'sd100;
		led_offset[3] = 11'sd150;
		top_now       = TOP_IDLE;
		ramp_now      = RP_INIT;
		lit_now       = 0;
		ramp_since    = '0;
		temp_now      = TP_INIT;
		sample_since  = '0;
		base_now      = '0;
		lamps         = '0;
		req_total     = 0;
		results_done  = 0;
		fail_count    = 0;
		cycle_count   = 0;
		gen_now       = 32'h40;
		gen_step      = 25;
		gen_center    = 2400;
		gen_held      = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Base at the top of its range, so thresholds run past the field width
		load_setup(1000, 500, 500, 16383, -100, 50, 100, 150);

		// Ramp: enter, clear, light all four, saturate, darken, re-press
		queue_req(32'd0, 1'b1, 1'b0, 15'sd2400);
		queue_req(32'd10, 1'b1, 1'b0, 15'sd2400);
		queue_req(32'd20, 1'b1, 1'b1, 15'sd2400);
		queue_req(32'd1020, 1'b1, 1'b1, 15'sd2400);
		queue_req(32'd2020, 1'b1, 1'b1, 15'sd2400);
		queue_req(32'd3020, 1'b1, 1'b1, 15'sd2400);
		queue_req(32'd4020, 1'b1, 1'b1, 15'sd2400);
		queue_req(32'd5020, 1'b1, 1'b1, 15'sd2400);
		queue_req(32'd5030, 1'b1, 1'b0, 15'sd2400);
		queue_req(32'd5530, 1'b1, 1'b0, 15'sd2400);
		queue_req(32'd5600, 1'b1, 1'b1, 15'sd2400);
		queue_req(32'd6600, 1'b1, 1'b1, 15'sd2400);
		// Temperature: LEDs kept across the switch, first pass loads the base
		queue_req(32'd6700, 1'b0, 1'b0, -15'sd16384);
		queue_req(32'd6710, 1'b0, 1'b0, -15'sd16384);
		queue_req(32'd6720, 1'b0, 1'b0, -15'sd16384);
		queue_req(32'd6800, 1'b0, 1'b0, 15'sd16383);
		queue_req(32'd7220, 1'b0, 1'b0, 15'sd16383);
		queue_req(32'd7230, 1'b0, 1'b0, 15'sd16383);
		// Button hold: slider ignored until release captures the base
		queue_req(32'd7240, 1'b0, 1'b1, 15'sd13000);
		queue_req(32'd7250, 1'b1, 1'b1, 15'sd13000);
		queue_req(32'd7260, 1'b1, 1'b0, -15'sd4500);
		queue_req(32'd7270, 1'b0, 1'b0, -15'sd4600);
		// Time wraps through zero
		queue_req(32'hFFFF_FF00, 1'b0, 1'b0, 15'sd13000);
		queue_req(32'h0000_0010, 1'b0, 1'b0, 15'sd13000);
		queue_req(32'h0000_0020, 1'b1, 1'b0, 15'sd0);
		queue_req(32'h0000_0030, 1'b1, 1'b1, 15'sd0);
		drain();

		load_setup(0, 0, 0, -16384, -1024, 1023, -1, 0);
		gen_step = 3;
		queue_random(80);
		drain();

		load_setup(65535, 65535, 65535, 0, 1023, -1024, 1023, -1024);
		gen_step = 30000;
		queue_random(60);
		drain();

		repeat (4) begin
			load_setup($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
				int'($urandom_range(0, 32767)) - 16384,
				int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
				int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024);
			gen_step = 25;
			queue_random(80);
			drain();
		end

		if (bar_expect_q.size() != 0) begin
			fail_count++;
			$display("%0t: %0d expected results never arrived", $time, bar_expect_q.size());
		end
		if (fail_count == 0)
			$display("led_bar_mode_controller_core verification clean");
		else
			$display("led_bar_mode_controller_core verification failed");
		$finish;
	end

endmodule
